### sv/i2cst_pkg.sv
// Package for the I2C slave buffer transceiver core.
// Holds word types, bus status codes, action codes and buffer sizing.
// No dependencies; every other file uses it by scoped names.
`default_nettype none

package i2cst_pkg;

  // Buffer sizing
  localparam int BUF_DEPTH = 16;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int PTR_W     = $clog2(BUF_DEPTH + 1);

  // Host action codes
  typedef enum logic [1:0] {
    ACT_BUS   = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_READ  = 2'd3
  } act_t;

  // Bus status codes
  localparam logic [7:0] ST_STX_ADR_ACK       = 8'hA8;
  localparam logic [7:0] ST_STX_DATA_ACK      = 8'hB8;
  localparam logic [7:0] ST_STX_DATA_NACK     = 8'hC0;
  localparam logic [7:0] ST_STX_LAST_ACK      = 8'hC8;
  localparam logic [7:0] ST_SRX_ADR_ACK       = 8'h60;
  localparam logic [7:0] ST_SRX_GEN_ACK       = 8'h70;
  localparam logic [7:0] ST_SRX_ADR_DATA_ACK  = 8'h80;
  localparam logic [7:0] ST_SRX_ADR_DATA_NACK = 8'h88;
  localparam logic [7:0] ST_SRX_GEN_DATA_ACK  = 8'h90;
  localparam logic [7:0] ST_SRX_GEN_DATA_NACK = 8'h98;
  localparam logic [7:0] ST_SRX_STOP_RESTART  = 8'hA0;
  localparam logic [7:0] ST_BUS_ERROR         = 8'h00;
  localparam logic [7:0] ST_NO_STATE          = 8'hF8;

  // Input word
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] bus_status;
    logic [7:0] bus_byte;
    logic [3:0] slot;
    logic [7:0] load_byte;
    logic       with_size;
    logic [4:0] message_size;
    logic       read_final;
  } in_t;

  // Result word
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       ack_next;
    logic       stop_recover;
    logic       busy_res;
    logic       last_ok;
    logic       rx_pending;
    logic       general_call;
    logic [7:0] error_code;
    logic [7:0] read_byte;
    logic       read_valid;
  } out_t;

  // Buffer access request from control to the buffer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } buf_req_t;

endpackage

`default_nettype wire

### sv/i2c_slave_buffer_transceiver_core.sv
// Top level of the I2C slave buffer transceiver core.
// Uses i2cst_pkg, i2cst_pipe and i2cst_core (i2cst_ctrl, i2cst_buf).
//
//   channel   ports                          payload
//   input     in_valid / in_stall / in_data  i2cst_pkg::in_t, one event or host access
//   result    out_valid / out_stall / out_data  i2cst_pkg::out_t, one result per word
//
// One word is taken every cycle while in_stall is low and waits in the input register;
// its result is then registered in the result register, from which it is taken.
// The decode between the input register and the result register is one pass
// over the state and one read of the 16-byte flop buffer.
// Synchronous active-low reset clears both valid bits and the control state;
// buffer contents are undefined until written.
// A stalled result holds the result register; the input register then holds
// one more word and in_stall rises.
`default_nettype none

module i2c_slave_buffer_transceiver_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  i2cst_pkg::in_t      in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output i2cst_pkg::out_t     out_data
);

  logic            fire;
  i2cst_pkg::in_t  word;
  i2cst_pkg::out_t res;

  // Handshake and registers
  i2cst_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fire      (fire),
    .word      (word),
    .res       (res)
  );

  // Decode, state and buffer
  i2cst_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (word),
    .res   (res)
  );

  // A read is only granted with the transceiver idle and the last transfer good
  a_read_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> !out_data.busy_res && out_data.last_ok)
    else $error("read granted while busy or after a failed transfer");

  // Stop recovery never acknowledges
  a_stop_nack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stop_recover |-> !out_data.ack_next)
    else $error("stop recovery with acknowledge");

  // A waiting word moves into the result register when that register is empty or not stalled
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("advanced word lost");

  // Input is stalled only while a word waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

`default_nettype wire

### sv/i2cst_buf.sv
// Data buffer of the I2C slave transceiver: one write port, one read port.
// Depends on i2cst_pkg for sizing and the request struct.
`default_nettype none

module i2cst_buf (
  input  wire logic                clk,
  input  i2cst_pkg::buf_req_t      req,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [i2cst_pkg::BUF_DEPTH];

  // Write the addressed byte
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read the addressed byte
  assign rd_data = mem[req.raddr];

endmodule

`default_nettype wire

### sv/i2cst_ctrl.sv
// Control of the I2C slave transceiver: pointer, length, flags, busy, error.
// Decodes one word per cycle into a result word and a buffer request; state advances only on fire.
// Depends on i2cst_pkg.
`default_nettype none

module i2cst_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  i2cst_pkg::in_t           word,
  input  wire logic [7:0]          rd_data,
  output i2cst_pkg::buf_req_t      req,
  output i2cst_pkg::out_t          res
);

  localparam int PW = i2cst_pkg::PTR_W;
  localparam int IW = i2cst_pkg::IDX_W;

  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic          busy_r, busy_nxt;
  logic          ok_r, ok_nxt;
  logic          rx_r, rx_nxt;
  logic          gen_r, gen_nxt;
  logic [7:0]    err_r, err_nxt;

  logic [IW-1:0] take_idx;
  logic [IW-1:0] slot_idx;

  // Wrap the pointer once it has reached the buffer depth
  assign take_idx = (ptr_r >= PW'(i2cst_pkg::BUF_DEPTH)) ? '0 : ptr_r[IW-1:0];
  assign slot_idx = IW'(word.slot);

  // Decode the word against the current state
  always_comb begin
    ptr_nxt  = ptr_r;
    len_nxt  = len_r;
    busy_nxt = busy_r;
    ok_nxt   = ok_r;
    rx_nxt   = rx_r;
    gen_nxt  = gen_r;
    err_nxt  = err_r;
    req      = '0;
    req.raddr = take_idx;
    res      = '0;

    case (i2cst_pkg::act_t'(word.action))
      i2cst_pkg::ACT_BUS: begin
        case (word.bus_status)
          i2cst_pkg::ST_STX_ADR_ACK: begin
            req.raddr   = '0;
            res.tx_byte = rd_data;
            ptr_nxt     = PW'(1);
            res.ack_next = 1'b1;
            busy_nxt    = 1'b1;
          end
          i2cst_pkg::ST_STX_DATA_ACK: begin
            res.tx_byte = rd_data;
            ptr_nxt     = PW'(take_idx) + PW'(1);
            res.ack_next = 1'b1;
            busy_nxt    = 1'b1;
          end
          i2cst_pkg::ST_STX_DATA_NACK: begin
            if (ptr_r == len_r) begin
              ok_nxt = 1'b1;
            end else begin
              err_nxt = word.bus_status;
            end
            res.ack_next = 1'b1;
            busy_nxt     = 1'b0;
          end
          i2cst_pkg::ST_SRX_GEN_ACK, i2cst_pkg::ST_SRX_ADR_ACK: begin
            if (word.bus_status == i2cst_pkg::ST_SRX_GEN_ACK) begin
              gen_nxt = 1'b1;
            end
            rx_nxt       = 1'b1;
            ptr_nxt      = '0;
            res.ack_next = 1'b1;
            busy_nxt     = 1'b1;
          end
          i2cst_pkg::ST_SRX_ADR_DATA_ACK, i2cst_pkg::ST_SRX_GEN_DATA_ACK: begin
            req.we       = 1'b1;
            req.waddr    = take_idx;
            req.wdata    = word.bus_byte;
            ptr_nxt      = PW'(take_idx) + PW'(1);
            ok_nxt       = 1'b1;
            res.ack_next = 1'b1;
            busy_nxt     = 1'b1;
          end
          i2cst_pkg::ST_SRX_STOP_RESTART: begin
            res.ack_next = 1'b1;
            busy_nxt     = 1'b0;
          end
          i2cst_pkg::ST_SRX_ADR_DATA_NACK, i2cst_pkg::ST_SRX_GEN_DATA_NACK,
          i2cst_pkg::ST_STX_LAST_ACK, i2cst_pkg::ST_BUS_ERROR: begin
            err_nxt          = word.bus_status;
            res.stop_recover = 1'b1;
          end
          default: begin
            err_nxt      = word.bus_status;
            res.ack_next = 1'b1;
            busy_nxt     = 1'b0;
          end
        endcase
      end
      i2cst_pkg::ACT_LOAD: begin
        req.we    = 1'b1;
        req.waddr = slot_idx;
        req.wdata = word.load_byte;
      end
      i2cst_pkg::ACT_START: begin
        if (!busy_r) begin
          if (word.with_size) begin
            if (32'(word.message_size) > i2cst_pkg::BUF_DEPTH) begin
              len_nxt = PW'(i2cst_pkg::BUF_DEPTH);
            end else begin
              len_nxt = PW'(word.message_size);
            end
            busy_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b0;
          end
          ok_nxt       = 1'b0;
          rx_nxt       = 1'b0;
          gen_nxt      = 1'b0;
          err_nxt      = i2cst_pkg::ST_NO_STATE;
          res.ack_next = 1'b1;
        end
      end
      i2cst_pkg::ACT_READ: begin
        req.raddr = slot_idx;
        if (!busy_r && ok_r) begin
          res.read_byte  = rd_data;
          res.read_valid = 1'b1;
          if (word.read_final) begin
            rx_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // Drop writes unless the word really advances
    req.we = req.we & fire;

    res.busy_res     = busy_nxt;
    res.last_ok      = ok_nxt;
    res.rx_pending   = rx_nxt;
    res.general_call = gen_nxt;
    res.error_code   = err_nxt;
  end

  // Hold state, advance on each word that passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      len_r  <= '0;
      busy_r <= 1'b0;
      ok_r   <= 1'b0;
      rx_r   <= 1'b0;
      gen_r  <= 1'b0;
      err_r  <= i2cst_pkg::ST_NO_STATE;
    end else if (fire) begin
      ptr_r  <= ptr_nxt;
      len_r  <= len_nxt;
      busy_r <= busy_nxt;
      ok_r   <= ok_nxt;
      rx_r   <= rx_nxt;
      gen_r  <= gen_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/i2cst_pipe.sv
// Input and result registers of the I2C slave transceiver with stall control.
// Depends on i2cst_pkg for the word types.
`default_nettype none

module i2cst_pipe (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  i2cst_pkg::in_t      in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output i2cst_pkg::out_t     out_data,
  output logic                fire,
  output i2cst_pkg::in_t      word,
  input  i2cst_pkg::out_t     res
);

  logic            in_valid_r;
  i2cst_pkg::in_t  in_word_r;
  logic            out_valid_r;
  i2cst_pkg::out_t out_word_r;
  logic            out_free;

  // Advance when the result register is empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= res;
    end
  end

  assign word      = in_word_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

### sv/i2cst_core.sv
// Decode core of the I2C slave transceiver: control state plus the byte buffer.
// Depends on i2cst_pkg, i2cst_ctrl and i2cst_buf.
`default_nettype none

module i2cst_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  i2cst_pkg::in_t      word,
  output i2cst_pkg::out_t     res
);

  i2cst_pkg::buf_req_t req;
  logic [7:0]          rd_data;

  // Control decode and state
  i2cst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .word    (word),
    .rd_data (rd_data),
    .req     (req),
    .res     (res)
  );

  // Byte buffer
  i2cst_buf u_buf (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
